// ===== rtl/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// spq_pkg
// types and codes shared by the sorted priority queue modules
// ----------------------------------------------------------------------------
package spq_pkg;

	localparam int unsigned DATA_W  = 32;
	localparam int unsigned COUNT_W = 8;
	localparam int unsigned APB_AW  = 3;
	localparam int unsigned APB_DW  = 32;

	localparam logic       MODE_ENQ = 1'b0;
	localparam logic       MODE_DEQ = 1'b1;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_OVERFLOW  = 2'd1;
	localparam logic [1:0] ST_UNDERFLOW = 2'd2;

	localparam logic [APB_AW-1:0] ADDR_CAPACITY = 3'h0;
	localparam logic [7:0]        CAPACITY_RST  = 8'd128;

	typedef logic signed [DATA_W-1:0] spq_data_t;

	typedef struct packed {
		logic      enq;
		logic      deq;
		spq_data_t value;
	} spq_ctrl_t;

endpackage

// ===== rtl/spq_if.sv =====
// ----------------------------------------------------------------------------
// spq_if
// valid/ready channels carrying request and response words
// ----------------------------------------------------------------------------
interface spq_req_if;
	logic               valid;
	logic               ready;
	logic               mode;
	logic signed [31:0] value;

	modport source (output valid, output mode, output value, input ready);
	modport sink   (input valid, input mode, input value, output ready);
endinterface

interface spq_rsp_if;
	logic               valid;
	logic               ready;
	logic        [1:0]  status;
	logic signed [31:0] head_value;
	logic               head_valid;
	logic        [7:0]  entry_count;

	modport source (output valid, output status, output head_value, output head_valid,
		output entry_count, input ready);
	modport sink   (input valid, input status, input head_value, input head_valid,
		input entry_count, output ready);
endinterface

// ===== rtl/spq_cell.sv =====
// ----------------------------------------------------------------------------
// spq_cell
// one slot of the sorted row: compares against the incoming word and
// shifts back on insert or forward on remove
// ----------------------------------------------------------------------------
module spq_cell
	import spq_pkg::*;
(
	input  logic      clk,
	input  spq_ctrl_t ctrl,
	input  logic      live,
	input  logic      left_take,
	input  spq_data_t left_value,
	input  spq_data_t right_value,
	output spq_data_t value_q,
	output logic      take
);

	// empty slot, or stored word not below the new one
	assign take = !live || (value_q >= ctrl.value);

	always_ff @(posedge clk) begin
		if (ctrl.enq && take) begin
			value_q <= left_take ? left_value : ctrl.value;
		end else if (ctrl.deq) begin
			value_q <= right_value;
		end
	end

endmodule

// ===== rtl/sorted_priority_queue.sv =====
// ----------------------------------------------------------------------------
// sorted_priority_queue
// minimum-first priority queue held in a row of compare-and-shift cells
// ----------------------------------------------------------------------------
// usage:
//   req carries a mode bit (enqueue or dequeue) and a signed value; rsp
//   returns one word per request with status, head value, head valid and
//   entry count after the operation.
//   every cell compares its entry with the new value in the accept cycle and
//   the whole row shifts on the next edge, so the response is valid in the
//   cycle after acceptance; one request can be taken every cycle unless stalled.
//   a single response register sits between the row and rsp; req stays ready
//   while that register is empty or being drained, so a stalled receiver
//   holds the response and blocks only the next request.
//   the APB port writes capacity at address 0 (limit on live entries,
//   clipped to DEPTH); the user must change capacity only while the queue
//   is idle, which the block does not enforce. reset empties the queue and
//   sets capacity to 128; entries are not cleared; only live cells reach rsp.
// ----------------------------------------------------------------------------
module sorted_priority_queue
	import spq_pkg::*;
#(
	parameter int unsigned DEPTH = 128
) (
	input  logic              clk,
	input  logic              arst_n,
	spq_req_if.sink           req,
	spq_rsp_if.source         rsp,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready
);

	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam int unsigned LW = (CW > COUNT_W) ? CW : COUNT_W;

	logic [CW-1:0]  count_q, count_d;
	logic [7:0]     capacity_q;
	logic           rsp_valid_q;
	logic [1:0]     status_q;
	spq_data_t      head_q;
	logic           head_valid_q;
	logic [7:0]     entry_count_q;

	logic [LW-1:0]  cap_ext, lim, cnt_ext;
	logic           fire, full, empty, enq_ok, deq_ok;
	logic [1:0]     status_d;
	spq_data_t      head_d;
	spq_ctrl_t      ctrl;

	spq_data_t      cell_value [DEPTH];
	logic [DEPTH-1:0] cell_take;
	logic [DEPTH-1:0] cell_live;

	// apb
	assign pready = 1'b1;
	assign prdata = (paddr[APB_AW-1:2] == ADDR_CAPACITY[APB_AW-1:2]) ?
		{{(APB_DW-8){1'b0}}, capacity_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAPACITY_RST;
		end else if (psel && penable && pwrite &&
			paddr[APB_AW-1:2] == ADDR_CAPACITY[APB_AW-1:2]) begin
			capacity_q <= pwdata[7:0];
		end
	end

	// request decode
	assign fire    = req.valid && req.ready;
	assign cap_ext = LW'(capacity_q);
	assign lim     = (cap_ext > LW'(DEPTH)) ? LW'(DEPTH) : cap_ext;
	assign cnt_ext = LW'(count_q);
	assign full    = cnt_ext >= lim;
	assign empty   = (count_q == '0);
	assign enq_ok  = fire && (req.mode == MODE_ENQ) && !full;
	assign deq_ok  = fire && (req.mode == MODE_DEQ) && !empty;

	assign ctrl = {enq_ok, deq_ok, req.value};

	always_comb begin
		count_d = count_q;
		if (enq_ok) begin
			count_d = count_q + CW'(1);
		end else if (deq_ok) begin
			count_d = count_q - CW'(1);
		end
	end

	always_comb begin
		status_d = ST_OK;
		if (req.mode == MODE_ENQ && full) begin
			status_d = ST_OVERFLOW;
		end else if (req.mode == MODE_DEQ && empty) begin
			status_d = ST_UNDERFLOW;
		end
	end

	// head after this operation
	always_comb begin
		head_d = cell_value[0];
		if (enq_ok && cell_take[0]) begin
			head_d = req.value;
		end else if (deq_ok) begin
			head_d = cell_value[1];
		end
		if (count_d == '0) begin
			head_d = '0;
		end
	end

	// cell row
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		assign cell_live[i] = count_q > CW'(i);
		spq_cell u_cell (
			.clk        (clk),
			.ctrl       (ctrl),
			.live       (cell_live[i]),
			.left_take  ((i == 0) ? 1'b0 : cell_take[(i == 0) ? 0 : i-1]),
			.left_value (cell_value[(i == 0) ? 0 : i-1]),
			.right_value(cell_value[(i == DEPTH-1) ? i : i+1]),
			.value_q    (cell_value[i]),
			.take       (cell_take[i])
		);
	end

	// count and response register
	assign req.ready = !rsp_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			count_q <= count_d;
			if (fire) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			status_q      <= status_d;
			head_q        <= head_d;
			head_valid_q  <= (count_d != '0);
			entry_count_q <= COUNT_W'(count_d);
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.status      = status_q;
	assign rsp.head_value  = head_q;
	assign rsp.head_valid  = head_valid_q;
	assign rsp.entry_count = entry_count_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		LW'(count_q) <= LW'(DEPTH))
		else $error("entry count beyond depth");

	a_enq_count: assert property (@(posedge clk) disable iff (!arst_n)
		enq_ok |=> count_q == $past(count_q) + CW'(1))
		else $error("enqueue did not advance count");

	a_overflow_hold: assert property (@(posedge clk) disable iff (!arst_n)
		fire && status_d == ST_OVERFLOW |=> $stable(count_q))
		else $error("overflow changed count");

	a_head_flag: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q |-> head_valid_q == (entry_count_q != 8'd0) || DEPTH > 255)
		else $error("head valid disagrees with count");
`endif

endmodule

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// checks the sorted priority queue against a behavioural shadow of its store
// ----------------------------------------------------------------------------
// every accepted request word is run through a shadow queue and the expected
// response is queued; every accepted response word is compared field by field
// with the oldest expectation. the run covers directed ordering and limit
// cases, random phases under several capacities, and a long receiver
// hold-off. the capacity register is written over apb only while the queue
// has no request in flight, and each write is read back.
// ----------------------------------------------------------------------------
module testbench;
	import spq_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int QDEPTH         = 128;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int HOLD_CYCLES    = 400;

	typedef struct {
		logic [1:0]         status;
		spq_data_t          head_value;
		logic               head_valid;
		logic [COUNT_W-1:0] entry_count;
	} queue_status_t;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic              pready;

	spq_req_if req_ch ();
	spq_rsp_if rsp_ch ();

	sorted_priority_queue #(
		.DEPTH   (QDEPTH)
	) u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_ch),
		.rsp     (rsp_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always #6 clk = ~clk;

	spq_data_t     shadow_entries [QDEPTH];
	int            shadow_count;
	logic [7:0]    shadow_capacity;
	queue_status_t expected_status [$];
	int            mismatch_count;
	int            stall_cycles;
	int            burst_left;
	int            gap_max;
	bit            sink_stalls;
	int            hold_request;

	function automatic queue_status_t predict_queue_op(logic mode, spq_data_t value);
		queue_status_t result;
		int            limit;
		int            pos;
		limit = (int'(shadow_capacity) > QDEPTH) ? QDEPTH : int'(shadow_capacity);
		result.status = ST_OK;
		if (mode == MODE_ENQ) begin
			if (shadow_count >= limit) begin
				result.status = ST_OVERFLOW;
			end else begin
				pos = shadow_count;
				for (int k = shadow_count - 1; k >= 0; k--) begin
					if (shadow_entries[k] >= value)
						pos = k;
				end
				for (int k = shadow_count; k > pos; k--)
					shadow_entries[k] = shadow_entries[k-1];
				shadow_entries[pos] = value;
				shadow_count++;
			end
		end else begin
			if (shadow_count == 0) begin
				result.status = ST_UNDERFLOW;
			end else begin
				for (int k = 0; k < shadow_count - 1; k++)
					shadow_entries[k] = shadow_entries[k+1];
				shadow_count--;
			end
		end
		result.head_value  = (shadow_count > 0) ? shadow_entries[0] : '0;
		result.head_valid  = (shadow_count > 0);
		result.entry_count = shadow_count[COUNT_W-1:0];
		return result;
	endfunction

	function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			mismatch_count++;
		end
	endfunction

	// response words are checked before the request of the same edge is predicted
	always @(posedge clk) begin
		queue_status_t want;
		if (arst_n) begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (expected_status.size() == 0) begin
					$error("response word with no request outstanding");
					mismatch_count++;
				end else begin
					want = expected_status.pop_front();
					compare_field("status", 32'(want.status), 32'(rsp_ch.status));
					compare_field("head_value", want.head_value, rsp_ch.head_value);
					compare_field("head_valid", 32'(want.head_valid), 32'(rsp_ch.head_valid));
					compare_field("entry_count", 32'(want.entry_count),
						32'(rsp_ch.entry_count));
				end
			end
			if (req_ch.valid && req_ch.ready)
				expected_status.push_back(predict_queue_op(req_ch.mode, req_ch.value));
		end
	end

	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
			(psel && penable)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("FAILURE");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	// receiver: random stall patterns from a 16-bit mask, plus an optional long hold-off
	initial begin
		int          phase;
		int          hold_left;
		logic [15:0] pattern;
		rsp_ch.ready = 1'b0;
		phase = 0;
		hold_left = 0;
		pattern = '1;
		forever begin
			@(negedge clk);
			if (phase == 0) begin
				case ($urandom_range(0, 3))
					0: pattern = '1;
					1: pattern = 16'($urandom);
					2: pattern = 16'($urandom | $urandom);
					default: pattern = 16'($urandom & $urandom);
				endcase
			end
			if (hold_request > 0) begin
				hold_left = hold_request;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= !sink_stalls || pattern[phase];
			end
			phase = (phase + 1) % 16;
		end
	end

	task automatic send_word(logic mode, spq_data_t value);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = (gap_max == 0 || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, gap_max);
			repeat (gap) begin
				@(negedge clk);
				req_ch.valid <= 1'b0;
			end
		end
		burst_left--;
		@(negedge clk);
		req_ch.valid <= 1'b1;
		req_ch.mode  <= mode;
		req_ch.value <= value;
		do @(posedge clk); while (!req_ch.ready);
	endtask

	task automatic sender_idle();
		@(negedge clk);
		req_ch.valid <= 1'b0;
	endtask

	task automatic wait_drained();
		while (expected_status.size() != 0)
			@(posedge clk);
	endtask

	task automatic apb_transfer(input logic is_write, input logic [APB_DW-1:0] wdata,
		output logic [APB_DW-1:0] rdata);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= is_write;
		paddr   <= ADDR_CAPACITY;
		pwdata  <= wdata;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic write_capacity(logic [7:0] cap);
		logic [APB_DW-1:0] rd;
		sender_idle();
		wait_drained();
		apb_transfer(1'b1, APB_DW'(cap), rd);
		shadow_capacity = cap;
		apb_transfer(1'b0, '0, rd);
		compare_field("capacity", 32'(shadow_capacity), 32'(rd[7:0]));
	endtask

	function automatic spq_data_t random_value();
		case ($urandom_range(0, 9))
			0: return 32'sh7FFFFFFF - spq_data_t'($urandom_range(0, 2));
			1: return 32'sh80000000 + spq_data_t'($urandom_range(0, 2));
			2, 3: return spq_data_t'(int'($urandom_range(0, 16)) - 8);
			default: return spq_data_t'($urandom);
		endcase
	endfunction

	task automatic test_ordering_and_underflow();
		logic [APB_DW-1:0] rd;
		apb_transfer(1'b0, '0, rd);
		compare_field("capacity", 32'(CAPACITY_RST), 32'(rd[7:0]));
		gap_max = 0;
		sink_stalls = 0;
		send_word(MODE_DEQ, 32'sh12345678);
		send_word(MODE_ENQ, 32'sh7FFFFFFF);
		send_word(MODE_ENQ, 32'sh80000000);
		send_word(MODE_ENQ, 32'sh00000000);
		send_word(MODE_ENQ, -32'sd1);
		send_word(MODE_ENQ, 32'sh00000000);
		send_word(MODE_ENQ, 32'sh80000000);
		repeat (6) send_word(MODE_DEQ, random_value());
		send_word(MODE_DEQ, 32'sh7FFFFFFF);
	endtask

	task automatic test_capacity_limits();
		write_capacity(8'd2);
		send_word(MODE_ENQ, 32'sd5);
		send_word(MODE_ENQ, 32'sd5);
		send_word(MODE_ENQ, -32'sd7);
		// limit now under the live count
		write_capacity(8'd0);
		send_word(MODE_ENQ, 32'sd1);
		send_word(MODE_DEQ, 32'sd0);
		send_word(MODE_DEQ, 32'sd0);
		send_word(MODE_ENQ, 32'sd3);
		send_word(MODE_DEQ, 32'sd0);
		write_capacity(8'd1);
		send_word(MODE_ENQ, 32'sh7FFFFFFF);
		send_word(MODE_ENQ, 32'sh80000000);
		send_word(MODE_DEQ, 32'sd0);
		sender_idle();
	endtask

	task automatic run_phase(logic [7:0] cap, int n_items, int enq_pct, int gap_limit,
		bit stalls);
		write_capacity(cap);
		gap_max = gap_limit;
		sink_stalls = stalls;
		repeat (n_items)
			send_word(($urandom_range(0, 99) < enq_pct) ? MODE_ENQ : MODE_DEQ, random_value());
		sender_idle();
	endtask

	task automatic test_random_phases();
		run_phase(8'd255, 260, 85, 0, 1'b0);
		run_phase(8'd128, 140, 30, 4, 1'b1);
		run_phase(8'd1,    60, 50, 2, 1'b1);
		run_phase(8'd3,    80, 50, 8, 1'b1);
		run_phase(8'd200, 150, 60, 3, 1'b1);
		run_phase(8'd20,  120, 55, 0, 1'b1);
		run_phase(8'd0,    40, 50, 1, 1'b0);
		run_phase(8'd128, 160, 50, 6, 1'b1);
		run_phase(8'd64,   80, 40, 2, 1'b1);
	endtask

	task automatic test_backpressure();
		write_capacity(8'd16);
		gap_max = 0;
		sink_stalls = 1'b0;
		@(posedge clk);
		hold_request = HOLD_CYCLES;
		repeat (30)
			send_word(($urandom_range(0, 99) < 70) ? MODE_ENQ : MODE_DEQ, random_value());
		sender_idle();
		wait_drained();
		gap_max = 3;
		sink_stalls = 1'b1;
		repeat (20)
			send_word(($urandom_range(0, 99) < 50) ? MODE_ENQ : MODE_DEQ, random_value());
		sender_idle();
	endtask

	initial begin
		arst_n          = 1'b0;
		req_ch.valid    = 1'b0;
		req_ch.mode     = MODE_ENQ;
		req_ch.value    = '0;
		psel            = 1'b0;
		penable         = 1'b0;
		pwrite          = 1'b0;
		paddr           = '0;
		pwdata          = '0;
		shadow_count    = 0;
		shadow_capacity = CAPACITY_RST;
		mismatch_count  = 0;
		stall_cycles    = 0;
		burst_left      = 0;
		gap_max         = 0;
		sink_stalls     = 1'b0;
		hold_request    = 0;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;

		test_ordering_and_underflow();
		test_capacity_limits();
		test_random_phases();
		test_backpressure();

		sender_idle();
		wait_drained();
		repeat (8) @(posedge clk);
		if (mismatch_count == 0 && expected_status.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
